// ===== design/tts_pkg.sv =====
`default_nettype none
package tts_pkg;

	localparam int TASK_SLOTS_DEF = 16;

	typedef enum logic [2:0] {
		OP_CREATE  = 3'd0,
		OP_DELETE  = 3'd1,
		OP_SUSPEND = 3'd2,
		OP_RESUME  = 3'd3,
		OP_SET     = 3'd4,
		OP_GET     = 3'd5,
		OP_DELAY   = 3'd6,
		OP_TICK    = 3'd7
	} op_t;

	localparam logic [2:0] ST_READY     = 3'd0;
	localparam logic [2:0] ST_RUNNING   = 3'd1;
	localparam logic [2:0] ST_BLOCKED   = 3'd2;
	localparam logic [2:0] ST_SUSPENDED = 3'd3;
	localparam logic [2:0] ST_DELETED   = 3'd4;

	localparam logic [1:0] RES_OK      = 2'd0;
	localparam logic [1:0] RES_INVALID = 2'd1;
	localparam logic [1:0] RES_REFUSED = 2'd2;

	localparam logic [6:0] NO_SLOT = 7'h7F;
	localparam logic [7:0] NO_ID   = 8'hFF;

	localparam logic [7:0] CFG_MAX_PRIORITY = 8'd0;
	localparam logic [7:0] CFG_MIN_STACK    = 8'd1;

	localparam logic [7:0]  MAX_PRIORITY_RST = 8'd3;
	localparam logic [15:0] MIN_STACK_RST    = 16'd256;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  task_id;
		logic [7:0]  priority_req;
		logic [31:0] stack_bytes;
		logic [31:0] sleep_ticks;
		logic [2:0]  target_state;
	} in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] assigned_id;
		logic [2:0] state_out;
		logic [7:0] priority_out;
		logic [6:0] live_count;
	} out_t;

	// operation token handed from cell to cell
	typedef struct packed {
		logic        vld;
		op_t         op;
		logic [7:0]  id;
		logic [7:0]  prio;
		logic [31:0] ticks;
		logic [2:0]  nst;
		logic        act;
		logic        found;
		logic [1:0]  status;
		logic [7:0]  assigned;
		logic [2:0]  st;
		logic [7:0]  pr;
	} tok_t;

endpackage
`default_nettype wire

// ===== design/tts_cell.sv =====
`default_nettype none
module tts_cell #(
	parameter int SLOT = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tts_pkg::tok_t tok_in,
	output tts_pkg::tok_t      tok_out
);
	import tts_pkg::*;

	localparam logic [7:0] SLOT_ID = 8'(SLOT);

	logic [2:0]  state_q;
	logic [7:0]  prio_q;
	logic [31:0] delay_q;
	logic        vld_q;
	tok_t        tok_q;

	logic [2:0]  state_d;
	logic [7:0]  prio_d;
	logic [31:0] delay_d;
	tok_t        tok_d;
	logic        hit;

	always_comb begin
		state_d = state_q;
		prio_d  = prio_q;
		delay_d = delay_q;
		tok_d   = tok_in;
		hit     = (tok_in.id == SLOT_ID);
		if (tok_in.vld && tok_in.act) begin
			case (tok_in.op)
				OP_CREATE: begin
					// take the first free slot along the chain
					if (!tok_in.found && state_q == ST_DELETED) begin
						state_d        = ST_READY;
						prio_d         = tok_in.prio;
						delay_d        = '0;
						tok_d.found    = 1'b1;
						tok_d.assigned = SLOT_ID;
						tok_d.status   = RES_OK;
					end
				end
				OP_DELETE: begin
					if (hit) begin
						if (state_q == ST_DELETED) tok_d.status = RES_REFUSED;
						else state_d = ST_DELETED;
					end
				end
				OP_SUSPEND: begin
					if (hit) begin
						if (state_q == ST_DELETED) tok_d.status = RES_REFUSED;
						else state_d = ST_SUSPENDED;
					end
				end
				OP_RESUME: begin
					if (hit) begin
						if (state_q != ST_SUSPENDED) tok_d.status = RES_REFUSED;
						else state_d = ST_READY;
					end
				end
				OP_SET: begin
					if (hit) begin
						if (state_q == ST_DELETED) tok_d.status = RES_REFUSED;
						else state_d = tok_in.nst;
					end
				end
				OP_GET: begin
					if (hit) begin
						tok_d.st = state_q;
						tok_d.pr = (state_q != ST_DELETED) ? prio_q : 8'd0;
					end
				end
				OP_DELAY: begin
					if (hit) begin
						delay_d = tok_in.ticks;
						state_d = ST_BLOCKED;
					end
				end
				OP_TICK: begin
					// zero delay keeps a blocked slot blocked
					if (state_q == ST_BLOCKED && delay_q != '0) begin
						delay_d = delay_q - 32'd1;
						if (delay_q == 32'd1) state_d = ST_READY;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DELETED;
			delay_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			delay_q <= delay_d;
			vld_q   <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= prio_d;
		if (tok_in.vld) tok_q <= tok_d;
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = vld_q;
	end

endmodule
`default_nettype wire

// ===== design/task_state_table_unit.sv =====
// An input transaction passes the register of each slot cell in turn, then the finish
// register, then the output register, before out_valid. The operation token walks
// the row of slot cells one cell per cycle; a new one enters only once the last result
// has moved on to the output register, where it waits while the next input is taken.
// Reset (arst_n low, asynchronous): all slots deleted, delays zero, live count zero,
// no running slot, max priority 3, minimum stack 256 bytes.
`default_nettype none
module task_state_table_unit #(
	parameter int TASK_SLOTS = tts_pkg::TASK_SLOTS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire tts_pkg::in_t in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output tts_pkg::out_t     out_data,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [7:0]   cfg_index,
	input  wire logic [15:0]  cfg_data
);
	import tts_pkg::*;

	localparam logic [7:0] SLOTS_ID  = 8'(TASK_SLOTS);
	localparam logic [6:0] SLOTS_CNT = 7'(TASK_SLOTS);

	logic [7:0]  max_prio_q;
	logic [15:0] min_stack_q;
	logic [6:0]  live_q;
	logic [6:0]  running_q;
	logic        busy_q;
	logic        fin_vld_q;
	out_t        fin_q;
	logic        out_vld_q;
	out_t        out_q;

	tok_t        chain [0:TASK_SLOTS];
	tok_t        ent;
	tok_t        last;
	logic        id_ok;
	logic [6:0]  live_d;
	logic [6:0]  running_d;
	logic        fin_move;

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_prio_q  <= MAX_PRIORITY_RST;
			min_stack_q <= MIN_STACK_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_MAX_PRIORITY) max_prio_q <= cfg_data[7:0];
			else if (cfg_index == CFG_MIN_STACK) min_stack_q <= cfg_data;
		end
	end

	// screen the operation against global state before it enters the row
	always_comb begin
		id_ok        = (in_data.task_id < SLOTS_ID);
		ent          = '0;
		ent.vld      = in_valid && !busy_q;
		ent.op       = op_t'(in_data.operation);
		ent.id       = in_data.task_id;
		ent.prio     = in_data.priority_req;
		ent.ticks    = in_data.sleep_ticks;
		ent.nst      = in_data.target_state;
		ent.assigned = NO_ID;
		ent.status   = RES_OK;
		ent.act      = 1'b0;
		case (ent.op)
			OP_CREATE: begin
				if (in_data.priority_req > max_prio_q
						|| in_data.stack_bytes < {16'd0, min_stack_q}) begin
					ent.status = RES_INVALID;
				end else if (live_q >= SLOTS_CNT) begin
					ent.status = RES_REFUSED;
				end else begin
					ent.status = RES_REFUSED;
					ent.act    = 1'b1;
				end
			end
			OP_DELETE, OP_SUSPEND, OP_RESUME: begin
				if (!id_ok) ent.status = RES_INVALID;
				else ent.act = 1'b1;
			end
			OP_SET: begin
				if (!id_ok || in_data.target_state > ST_DELETED) ent.status = RES_INVALID;
				else ent.act = 1'b1;
			end
			OP_GET: begin
				if (!id_ok) begin
					ent.status = RES_INVALID;
					ent.st     = ST_DELETED;
				end else begin
					ent.act = 1'b1;
				end
			end
			OP_DELAY: begin
				if (running_q < SLOTS_CNT) begin
					ent.id  = {1'b0, running_q};
					ent.act = 1'b1;
				end else begin
					ent.status = RES_REFUSED;
				end
			end
			OP_TICK: ent.act = 1'b1;
			default: ;
		endcase
	end

	assign chain[0] = ent;

	for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
		tts_cell #(.SLOT(g)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain[g]),
			.tok_out (chain[g + 1])
		);
	end

	assign last = chain[TASK_SLOTS];

	always_comb begin
		live_d    = live_q;
		running_d = running_q;
		if (last.act) begin
			case (last.op)
				OP_CREATE: if (last.found) live_d = live_q + 7'd1;
				OP_DELETE: begin
					if (last.status == RES_OK && live_q != '0) live_d = live_q - 7'd1;
				end
				OP_SET: begin
					if (last.status == RES_OK && last.nst == ST_RUNNING)
						running_d = last.id[6:0];
				end
				default: ;
			endcase
		end
	end

	assign fin_move = fin_vld_q && (!out_vld_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= '0;
			running_q <= NO_SLOT;
			busy_q    <= 1'b0;
			fin_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (last.vld) begin
				live_q    <= live_d;
				running_q <= running_d;
			end
			if (ent.vld) busy_q <= 1'b1;
			else if (fin_move) busy_q <= 1'b0;
			if (last.vld) fin_vld_q <= 1'b1;
			else if (fin_move) fin_vld_q <= 1'b0;
			if (fin_move) out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last.vld) begin
			fin_q.status       <= last.status;
			fin_q.assigned_id  <= last.assigned;
			fin_q.state_out    <= last.st;
			fin_q.priority_out <= last.pr;
			fin_q.live_count   <= live_d;
		end
		if (fin_move) out_q <= fin_q;
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		last.vld |-> busy_q)
		else $error("token left the row with no transaction in flight");
	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin_vld_q |-> busy_q && !last.vld)
		else $error("finished result overlaps another token");
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= SLOTS_CNT)
		else $error("live count above table size");
	a_running: assert property (@(posedge clk) disable iff (!arst_n)
		running_q == NO_SLOT || running_q < SLOTS_CNT)
		else $error("running slot out of range");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ent.vld |=> !in_ready)
		else $error("input ready while a transaction walks the row");

endmodule
`default_nettype wire
